FILE: hw/rtl/tlvdf_pkg.sv
// shared types, message codes and defaults for the tlv input message deframer
package tlvdf_pkg;

	localparam int DEF_MAX_PAYLOAD    = 256;
	localparam int DEF_SCANCODE_BYTES = 64;

	// payload bytes kept for decoding, banked as eight byte lanes of eight rows
	localparam int STORE_DEPTH = 64;
	localparam int STORE_LANES = 8;
	localparam int STORE_ROWS  = STORE_DEPTH / STORE_LANES;
	localparam int HEAD_BYTES  = 9;

	localparam logic [7:0]  TYPE_ACTION = 8'h01;
	localparam logic [7:0]  TYPE_SCAN   = 8'h02;
	localparam logic [7:0]  TYPE_MOUSE  = 8'h03;
	localparam logic [15:0] LEN_ACTION  = 16'd12;
	localparam logic [15:0] LEN_MOUSE   = 16'd5;
	localparam int          ACTION_BUTTON_BIT = 4;

	localparam logic [7:0] VERSION_RESET = 8'h01;

	localparam logic [2:0] KIND_ACTION   = 3'd0;
	localparam logic [2:0] KIND_SCAN     = 3'd1;
	localparam logic [2:0] KIND_MOUSE    = 3'd2;
	localparam logic [2:0] KIND_REJECT   = 3'd3;
	localparam logic [2:0] KIND_OVERSIZE = 3'd4;

	typedef struct packed {
		logic       action;
		logic [7:0] data_byte;
	} in_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [23:0] key_bits;
		logic [3:0]  weapon_bits;
		logic        button;
		logic [15:0] pointer_x;
		logic [15:0] pointer_y;
		logic [63:0] scan_word;
		logic [2:0]  scan_index;
		logic        last;
	} out_t;

	typedef struct packed {
		logic       load_type;
		logic       load_len_lo;
		logic       load_len_hi;
		logic       clr_count;
		logic       store_byte;
		logic       scan_start;
		logic       scan_rd;
		logic       scan_next;
		logic       emit;
		logic [2:0] emit_kind;
		logic       emit_last;
	} cmd_t;

	typedef struct packed {
		logic version_ok;
		logic len_over;
		logic len_zero;
		logic pay_last;
		logic is_action;
		logic is_mouse;
		logic is_scan;
		logic scan_last_word;
		logic out_free;
	} sts_t;

endpackage

FILE: hw/rtl/tlv_input_message_deframer_top.sv
// top level of the tlv input message deframer: controller plus datapath
// a result is registered the cycle after its completing byte; scan words first pass ST_SCAN_RD
// throughput: one byte per cycle while the output register drains, outside scancode bursts
// a scancode bitmap holds the input for each 64-bit word while it is fetched by the
// registered read of the byte-lane payload memories
// reset: asynchronous, active low; clears phase and output valid, version back to 1
module tlv_input_message_deframer_top #(
	parameter int MAX_PAYLOAD    = tlvdf_pkg::DEF_MAX_PAYLOAD,
	parameter int SCANCODE_BYTES = tlvdf_pkg::DEF_SCANCODE_BYTES
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  tlvdf_pkg::in_t  in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output tlvdf_pkg::out_t out_data,
	input  logic            cfg_wr_en,
	input  logic [7:0]      cfg_wr_data
);
	import tlvdf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	tlvdf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_action (in_data.action),
		.in_stall  (in_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tlvdf_dpath #(
		.MAX_PAYLOAD    (MAX_PAYLOAD),
		.SCANCODE_BYTES (SCANCODE_BYTES)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_byte   (in_data.data_byte),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

endmodule

FILE: hw/rtl/tlvdf_ctrl.sv
// deframer controller: connection phase, header parse and scancode burst sequencing
module tlvdf_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_action,
	output logic            in_stall,
	input  tlvdf_pkg::sts_t sts,
	output tlvdf_pkg::cmd_t cmd
);
	import tlvdf_pkg::*;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_VERSION  = 3'd1;
	localparam logic [2:0] ST_HDR_TYPE = 3'd2;
	localparam logic [2:0] ST_HDR_LO   = 3'd3;
	localparam logic [2:0] ST_HDR_HI   = 3'd4;
	localparam logic [2:0] ST_PAYLOAD  = 3'd5;
	localparam logic [2:0] ST_SCAN_RD  = 3'd6;
	localparam logic [2:0] ST_SCAN_OUT = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_n;
	logic       accept;

	assign in_stall = (state_q == ST_SCAN_RD) || (state_q == ST_SCAN_OUT) || !sts.out_free;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_n = state_q;
		cmd     = '0;
		if (accept && in_action) begin
			state_n = ST_VERSION;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
				end
				ST_VERSION: begin
					if (accept) begin
						if (sts.version_ok) begin
							state_n = ST_HDR_TYPE;
						end else begin
							cmd.emit      = 1'b1;
							cmd.emit_kind = KIND_REJECT;
							cmd.emit_last = 1'b1;
							state_n       = ST_IDLE;
						end
					end
				end
				ST_HDR_TYPE: begin
					if (accept) begin
						cmd.load_type = 1'b1;
						state_n       = ST_HDR_LO;
					end
				end
				ST_HDR_LO: begin
					if (accept) begin
						cmd.load_len_lo = 1'b1;
						state_n         = ST_HDR_HI;
					end
				end
				ST_HDR_HI: begin
					if (accept) begin
						cmd.load_len_hi = 1'b1;
						cmd.clr_count   = 1'b1;
						if (sts.len_over) begin
							cmd.emit      = 1'b1;
							cmd.emit_kind = KIND_OVERSIZE;
							cmd.emit_last = 1'b1;
							state_n       = ST_IDLE;
						end else if (sts.len_zero) begin
							// empty message never matches a decoded type
							state_n = ST_HDR_TYPE;
						end else begin
							state_n = ST_PAYLOAD;
						end
					end
				end
				ST_PAYLOAD: begin
					if (accept) begin
						cmd.store_byte = 1'b1;
						if (sts.pay_last) begin
							state_n = ST_HDR_TYPE;
							if (sts.is_action) begin
								cmd.emit      = 1'b1;
								cmd.emit_kind = KIND_ACTION;
								cmd.emit_last = 1'b1;
							end else if (sts.is_scan) begin
								cmd.scan_start = 1'b1;
								state_n        = ST_SCAN_RD;
							end else if (sts.is_mouse) begin
								cmd.emit      = 1'b1;
								cmd.emit_kind = KIND_MOUSE;
								cmd.emit_last = 1'b1;
							end
						end
					end
				end
				ST_SCAN_RD: begin
					cmd.scan_rd = 1'b1;
					state_n     = ST_SCAN_OUT;
				end
				ST_SCAN_OUT: begin
					if (sts.out_free) begin
						cmd.emit      = 1'b1;
						cmd.emit_kind = KIND_SCAN;
						cmd.emit_last = sts.scan_last_word;
						if (sts.scan_last_word) begin
							state_n = ST_HDR_TYPE;
						end else begin
							cmd.scan_next = 1'b1;
							state_n       = ST_SCAN_RD;
						end
					end
				end
				default: begin
					state_n = ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// no input transfer may slip in while scancode words are being read out
	a_scan_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN_RD || state_q == ST_SCAN_OUT) |-> in_stall)
		else $error("input accepted during scancode burst");

	a_reject_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.emit_kind == KIND_REJECT) |=> state_q == ST_IDLE)
		else $error("handshake rejection did not close the connection");

	a_scan_end_to_header: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.emit_kind == KIND_SCAN && cmd.emit_last) |=> state_q == ST_HDR_TYPE)
		else $error("scancode burst did not return to header parse");

	a_emit_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result issued while output register held");

endmodule

FILE: hw/rtl/tlvdf_dpath.sv
// deframer datapath: header registers, payload store, result build and output register
module tlvdf_dpath #(
	parameter int MAX_PAYLOAD    = tlvdf_pkg::DEF_MAX_PAYLOAD,
	parameter int SCANCODE_BYTES = tlvdf_pkg::DEF_SCANCODE_BYTES
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       data_byte,
	input  logic             cfg_wr_en,
	input  logic [7:0]       cfg_wr_data,
	input  tlvdf_pkg::cmd_t  cmd,
	output tlvdf_pkg::sts_t  sts,
	output logic             out_valid,
	input  logic             out_stall,
	output tlvdf_pkg::out_t  out_data
);
	import tlvdf_pkg::*;

	localparam int CntW      = $clog2(MAX_PAYLOAD + 1);
	localparam int ScanWords = (SCANCODE_BYTES + 7) / 8;

	logic [7:0]      version_q;
	logic [7:0]      type_q;
	logic [7:0]      len_lo_q;
	logic [15:0]     len_q;
	logic [CntW-1:0] cnt_q;
	logic [15:0]     cnt_ext;
	logic [15:0]     len_in;
	logic            store_wr;
	logic [2:0]      wr_lane;
	logic [2:0]      wr_row;
	logic [2:0]      word_q;
	logic [7:0]      head_q [HEAD_BYTES];
	logic [7:0]      head_n [HEAD_BYTES];
	logic [7:0]      rd_data_q [STORE_LANES];
	logic [63:0]     scan_word;
	logic            out_valid_q;
	out_t            out_q;
	out_t            out_n;

	assign cnt_ext  = {{(16 - CntW){1'b0}}, cnt_q};
	assign len_in   = {data_byte, len_lo_q};
	assign store_wr = cmd.store_byte && (cnt_ext < 16'(STORE_DEPTH));
	assign wr_lane  = cnt_ext[2:0];
	assign wr_row   = cnt_ext[5:3];

	assign sts.version_ok     = (data_byte == version_q);
	assign sts.len_over       = (len_in > 16'(MAX_PAYLOAD));
	assign sts.len_zero       = (len_in == 16'd0);
	// length is at most MAX_PAYLOAD here, so it fits the count width
	assign sts.pay_last       = (CntW'(cnt_q + CntW'(1)) == len_q[CntW-1:0]);
	assign sts.is_action      = (type_q == TYPE_ACTION) && (len_q == LEN_ACTION);
	assign sts.is_mouse       = (type_q == TYPE_MOUSE) && (len_q == LEN_MOUSE);
	assign sts.is_scan        = (type_q == TYPE_SCAN) && (len_q == 16'(SCANCODE_BYTES));
	assign sts.scan_last_word = (word_q == 3'(ScanWords - 1));
	assign sts.out_free       = !(out_valid_q && out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q <= VERSION_RESET;
		end else if (cfg_wr_en) begin
			version_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_type) begin
			type_q <= data_byte;
		end
		if (cmd.load_len_lo) begin
			len_lo_q <= data_byte;
		end
		if (cmd.load_len_hi) begin
			len_q <= len_in;
		end
		if (cmd.clr_count) begin
			cnt_q <= '0;
		end else if (cmd.store_byte) begin
			cnt_q <= CntW'(cnt_q + CntW'(1));
		end
		if (cmd.scan_start) begin
			word_q <= '0;
		end else if (cmd.scan_next) begin
			word_q <= 3'(word_q + 3'd1);
		end
	end

	// leading payload bytes, with the byte of this transfer passed through
	always_comb begin
		for (int k = 0; k < HEAD_BYTES; k++) begin
			head_n[k] = (cmd.store_byte && cnt_ext == 16'(k)) ? data_byte : head_q[k];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < HEAD_BYTES; k++) begin
			head_q[k] <= head_n[k];
		end
	end

	// one byte-lane memory per position within a scancode word
	for (genvar j = 0; j < STORE_LANES; j++) begin : g_lane
		logic [7:0] lane_mem [STORE_ROWS];

		always_ff @(posedge clk) begin
			if (store_wr && wr_lane == 3'(j)) begin
				lane_mem[wr_row] <= data_byte;
			end
			if (cmd.scan_rd) begin
				rd_data_q[j] <= lane_mem[word_q];
			end
		end

		// bytes past the bitmap end read as zero
		assign scan_word[8*j +: 8] = ({3'b000, word_q, 3'(j)} < 9'(SCANCODE_BYTES)) ?
			rd_data_q[j] : 8'h00;
	end

	always_comb begin
		out_n      = '0;
		out_n.kind = cmd.emit_kind;
		out_n.last = cmd.emit_last;
		case (cmd.emit_kind)
			KIND_ACTION: begin
				out_n.key_bits    = {head_n[2], head_n[1], head_n[0]};
				out_n.weapon_bits = head_n[4][3:0];
				out_n.button      = head_n[4][ACTION_BUTTON_BIT];
				out_n.pointer_x   = {head_n[6], head_n[5]};
				out_n.pointer_y   = {head_n[8], head_n[7]};
			end
			KIND_MOUSE: begin
				out_n.button    = head_n[4][0];
				out_n.pointer_x = {head_n[1], head_n[0]};
				out_n.pointer_y = {head_n[3], head_n[2]};
			end
			KIND_SCAN: begin
				out_n.scan_word  = scan_word;
				out_n.scan_index = word_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= out_n;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_scan_index_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.emit_kind == KIND_SCAN) |=> out_data.scan_index == $past(word_q))
		else $error("scancode word index out of step");

	a_no_store_after_open_len: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store_byte |-> cnt_ext < len_q)
		else $error("payload byte stored past message length");

endmodule

FILE: tb/sv/tlv_input_message_deframer_top_test.sv
// self-checking testbench for the tlv input message deframer top level
module tlv_input_message_deframer_top_test;

	import tlvdf_pkg::*;

	localparam int MAX_LEN        = DEF_MAX_PAYLOAD;
	localparam int SCAN_BYTES     = DEF_SCANCODE_BYTES;
	localparam int SCAN_WORDS     = ((SCAN_BYTES + 7) / 8 > 8) ? 8 : (SCAN_BYTES + 7) / 8;
	localparam int TIMEOUT_CYCLES = 400000;
	localparam int REPORT_LIMIT   = 10;
	localparam int RANDOM_ITEMS   = 20;

	typedef enum logic [1:0] {
		LINK_IDLE,
		LINK_VERSION,
		LINK_HEADER,
		LINK_PAYLOAD
	} link_state_e;

	typedef enum int {
		FILL_RANDOM,
		FILL_ONES,
		FILL_ZEROS
	} fill_e;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_t  in_data;
	logic out_valid;
	logic out_stall;
	out_t out_data;
	logic cfg_wr_en;
	logic [7:0] cfg_wr_data;

	// predictor state
	link_state_e link_state;
	logic [1:0]  hdr_count;
	logic [7:0]  msg_type;
	logic [15:0] msg_len;
	logic [8:0]  pay_count;
	logic [7:0]  pay_store [STORE_DEPTH];
	logic [7:0]  version_reg;

	out_t expected_results [$];
	logic [7:0] frame_body [$];

	int fail_count = 0;
	int sent_count = 0;
	int cycle_count = 0;
	bit tx_gaps_on = 1'b1;
	bit rx_gaps_on = 1'b1;
	int rx_hold_request = 0;
	int rx_hold_left = 0;
	int rx_burst_left = 0;
	out_t want;

	tlv_input_message_deframer_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= TIMEOUT_CYCLES);
		$display("FAIL tlv_input_message_deframer_top");
		$finish;
	end

	function automatic string show_result(input out_t r);
		return $sformatf(
			"kind=%0d key=%06h wpn=%0h btn=%0b x=%04h y=%04h scan=%016h idx=%0d last=%0b",
			r.kind, r.key_bits, r.weapon_bits, r.button, r.pointer_x, r.pointer_y,
			r.scan_word, r.scan_index, r.last);
	endfunction

	function automatic void note_failure(input string what, input out_t exp_r, input out_t act_r);
		fail_count++;
		if (fail_count <= REPORT_LIMIT) begin
			$display("mismatch (%s) at cycle %0d", what, cycle_count);
			$display("  expected %s", show_result(exp_r));
			$display("  actual   %s", show_result(act_r));
		end
	endfunction

	function automatic void reset_model();
		link_state  = LINK_IDLE;
		hdr_count   = '0;
		msg_type    = '0;
		msg_len     = '0;
		pay_count   = '0;
		version_reg = VERSION_RESET;
		for (int i = 0; i < STORE_DEPTH; i++) pay_store[i] = '0;
	endfunction

	// turn the captured message into decoded results, if type and length match
	function automatic void decode_message();
		out_t r;
		logic [63:0] acc;
		int idx;
		r = '0;
		if (msg_type == TYPE_ACTION && msg_len == LEN_ACTION) begin
			r.kind        = KIND_ACTION;
			r.key_bits    = {pay_store[2], pay_store[1], pay_store[0]};
			r.weapon_bits = pay_store[4][3:0];
			r.button      = pay_store[4][ACTION_BUTTON_BIT];
			r.pointer_x   = {pay_store[6], pay_store[5]};
			r.pointer_y   = {pay_store[8], pay_store[7]};
			r.last        = 1'b1;
			expected_results.push_back(r);
		end else if (msg_type == TYPE_SCAN && msg_len == SCAN_BYTES) begin
			for (int w = 0; w < SCAN_WORDS; w++) begin
				acc = '0;
				for (int j = 0; j < 8; j++) begin
					idx = w * 8 + j;
					if (idx < SCAN_BYTES)
						acc = acc | ({56'd0, pay_store[idx[5:0]]} << (8 * j));
				end
				r            = '0;
				r.kind       = KIND_SCAN;
				r.scan_word  = acc;
				r.scan_index = w[2:0];
				r.last       = (w == SCAN_WORDS - 1);
				expected_results.push_back(r);
			end
		end else if (msg_type == TYPE_MOUSE && msg_len == LEN_MOUSE) begin
			r.kind      = KIND_MOUSE;
			r.button    = pay_store[4][0];
			r.pointer_x = {pay_store[1], pay_store[0]};
			r.pointer_y = {pay_store[3], pay_store[2]};
			r.last      = 1'b1;
			expected_results.push_back(r);
		end
	endfunction

	function automatic void deframe_byte(input in_t item);
		out_t r;
		logic [7:0] b;
		r = '0;
		r.last = 1'b1;
		b = item.data_byte;
		if (item.action) begin
			link_state = LINK_VERSION;
			hdr_count  = '0;
			msg_type   = '0;
			msg_len    = '0;
			pay_count  = '0;
		end else begin
			case (link_state)
				LINK_VERSION: begin
					if (b == version_reg) begin
						link_state = LINK_HEADER;
						hdr_count  = '0;
					end else begin
						r.kind = KIND_REJECT;
						expected_results.push_back(r);
						link_state = LINK_IDLE;
					end
				end
				LINK_HEADER: begin
					if (hdr_count == 2'd0) begin
						msg_type  = b;
						hdr_count = 2'd1;
					end else if (hdr_count == 2'd1) begin
						msg_len   = {8'd0, b};
						hdr_count = 2'd2;
					end else begin
						msg_len[15:8] = b;
						hdr_count     = '0;
						pay_count     = '0;
						if (msg_len > MAX_LEN) begin
							r.kind = KIND_OVERSIZE;
							expected_results.push_back(r);
							link_state = LINK_IDLE;
						end else if (msg_len == 0) begin
							decode_message();
						end else begin
							link_state = LINK_PAYLOAD;
						end
					end
				end
				LINK_PAYLOAD: begin
					// bytes beyond the store are counted only
					if (pay_count < STORE_DEPTH) pay_store[pay_count[5:0]] = b;
					pay_count = pay_count + 1'b1;
					if (pay_count >= msg_len) begin
						decode_message();
						link_state = LINK_HEADER;
						hdr_count  = '0;
						pay_count  = '0;
					end
				end
				default: ;
			endcase
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				note_failure("no result expected", '0, out_data);
			end else begin
				want = expected_results.pop_front();
				if (out_data.kind !== want.kind || out_data.key_bits !== want.key_bits ||
						out_data.weapon_bits !== want.weapon_bits ||
						out_data.button !== want.button ||
						out_data.pointer_x !== want.pointer_x ||
						out_data.pointer_y !== want.pointer_y ||
						out_data.scan_word !== want.scan_word ||
						out_data.scan_index !== want.scan_index ||
						out_data.last !== want.last)
					note_failure("field", want, out_data);
			end
		end
	end

	// receiver: random stall bursts plus an optional long hold-off
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_request > 0) begin
				rx_hold_left    = rx_hold_request;
				rx_hold_request = 0;
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				out_stall <= 1'b1;
			end else if (rx_gaps_on && rx_burst_left > 0) begin
				rx_burst_left--;
				out_stall <= 1'b1;
			end else if (rx_gaps_on && $urandom_range(0, 5) == 0) begin
				rx_burst_left = $urandom_range(0, 15);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// offer one item and hold it until the transfer
	task automatic send_item(input in_t item);
		int gap;
		if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 16);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent_count++;
		deframe_byte(item);
	endtask

	task automatic send_data(input logic [7:0] b);
		in_t item;
		item.action    = 1'b0;
		item.data_byte = b;
		send_item(item);
	endtask

	task automatic send_open();
		in_t item;
		logic [7:0] junk;
		junk           = 8'($urandom);
		item.action    = 1'b1;
		item.data_byte = junk;
		send_item(item);
	endtask

	task automatic fill_body(input int n, input fill_e mode);
		logic [7:0] b;
		frame_body.delete();
		for (int i = 0; i < n; i++) begin
			case (mode)
				FILL_ONES:  b = 8'hFF;
				FILL_ZEROS: b = 8'h00;
				default:    b = 8'($urandom);
			endcase
			frame_body.push_back(b);
		end
	endtask

	function automatic fill_e pick_fill();
		case ($urandom_range(0, 7))
			0:       return FILL_ONES;
			1:       return FILL_ZEROS;
			default: return FILL_RANDOM;
		endcase
	endfunction

	// header then whatever body bytes are queued, which may be short of len
	task automatic send_frame(input logic [7:0] typ, input logic [15:0] len);
		send_data(typ);
		send_data(len[7:0]);
		send_data(len[15:8]);
		foreach (frame_body[i]) send_data(frame_body[i]);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		// a dropped message leaves no result to wait for
		repeat (4) @(posedge clk);
	endtask

	task automatic set_version(input logic [7:0] v);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		version_reg = v;
	endtask

	task automatic test_stray_bytes();
		send_data(8'h00);
		send_data(8'hFF);
		send_data(VERSION_RESET);
	endtask

	task automatic test_handshake_reject();
		send_open();
		send_data(8'h00);
		send_data(version_reg);
		send_open();
		send_open();
		send_data(8'hFE);
	endtask

	task automatic test_action_and_mouse();
		send_open();
		send_data(version_reg);
		fill_body(int'(LEN_ACTION), FILL_ONES);
		send_frame(TYPE_ACTION, LEN_ACTION);
		fill_body(int'(LEN_MOUSE), FILL_ZEROS);
		send_frame(TYPE_MOUSE, LEN_MOUSE);
	endtask

	task automatic test_length_cases();
		send_open();
		send_data(version_reg);
		fill_body(0, FILL_RANDOM);
		send_frame(TYPE_ACTION, 16'd0);
		fill_body(5, FILL_RANDOM);
		send_frame(8'h00, 16'd5);
		fill_body(8, FILL_RANDOM);
		send_frame(TYPE_SCAN, 16'd8);
		fill_body(0, FILL_RANDOM);
		send_frame(TYPE_ACTION, 16'(MAX_LEN + 1));
		send_data(8'h5A);
		// open in the middle of a payload drops the message
		send_open();
		send_data(version_reg);
		fill_body(3, FILL_RANDOM);
		send_frame(TYPE_ACTION, LEN_ACTION);
		send_open();
		send_data(version_reg);
		fill_body(0, FILL_RANDOM);
		send_frame(TYPE_SCAN, 16'hFFFF);
	endtask

	task automatic test_scancode();
		send_open();
		send_data(version_reg);
		fill_body(SCAN_BYTES, FILL_RANDOM);
		send_frame(TYPE_SCAN, 16'(SCAN_BYTES));
	endtask

	task automatic test_version_register();
		set_version(8'h00);
		send_open();
		send_data(8'h00);
		fill_body(int'(LEN_MOUSE), FILL_RANDOM);
		send_frame(TYPE_MOUSE, LEN_MOUSE);
		set_version(8'hFF);
		send_open();
		send_data(8'hFE);
		send_open();
		send_data(8'hFF);
		fill_body(int'(LEN_MOUSE), FILL_RANDOM);
		send_frame(TYPE_MOUSE, LEN_MOUSE);
	endtask

	task automatic test_backpressure();
		send_open();
		send_data(version_reg);
		rx_hold_request = 400;
		fill_body(int'(LEN_ACTION), FILL_RANDOM);
		send_frame(TYPE_ACTION, LEN_ACTION);
		fill_body(int'(LEN_MOUSE), FILL_RANDOM);
		send_frame(TYPE_MOUSE, LEN_MOUSE);
		wait_idle();
	endtask

	// one connection: mostly well-formed frames, some broken ones
	task automatic random_connection();
		logic [7:0] bad;
		logic [7:0] typ;
		logic [15:0] len;
		int n_msgs;
		int pick;
		send_open();
		if ($urandom_range(0, 9) == 0) begin
			bad = 8'($urandom_range(1, 255));
			send_data(version_reg ^ bad);
			repeat ($urandom_range(0, 3)) send_data(8'($urandom));
			return;
		end
		send_data(version_reg);
		n_msgs = $urandom_range(1, 6);
		for (int m = 0; m < n_msgs; m++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				fill_body(int'(LEN_ACTION), pick_fill());
				send_frame(TYPE_ACTION, LEN_ACTION);
			end else if (pick < 65) begin
				fill_body(int'(LEN_MOUSE), pick_fill());
				send_frame(TYPE_MOUSE, LEN_MOUSE);
			end else if (pick < 70) begin
				fill_body(SCAN_BYTES, pick_fill());
				send_frame(TYPE_SCAN, 16'(SCAN_BYTES));
			end else if (pick < 85) begin
				case ($urandom_range(0, 3))
					0:       typ = TYPE_ACTION;
					1:       typ = TYPE_SCAN;
					2:       typ = TYPE_MOUSE;
					default: typ = 8'($urandom);
				endcase
				len = 16'($urandom_range(0, 20));
				fill_body(int'(len), FILL_RANDOM);
				send_frame(typ, len);
			end else if (pick < 91) begin
				case ($urandom_range(0, 3))
					0:       len = 16'(MAX_LEN + 1);
					1:       len = 16'hFFFF;
					default: len = 16'($urandom_range(MAX_LEN + 1, 65535));
				endcase
				typ = 8'($urandom);
				fill_body(0, FILL_RANDOM);
				send_frame(typ, len);
				repeat ($urandom_range(0, 3)) send_data(8'($urandom));
				return;
			end else begin
				// cut the frame short, the next open abandons it
				typ = ($urandom_range(0, 1) == 0) ? TYPE_ACTION : TYPE_MOUSE;
				len = (typ == TYPE_ACTION) ? LEN_ACTION : LEN_MOUSE;
				fill_body($urandom_range(0, len - 1), FILL_RANDOM);
				send_frame(typ, len);
				return;
			end
		end
	endtask

	task automatic test_random_traffic();
		int first_item;
		logic [7:0] v;
		first_item = sent_count;
		while (sent_count - first_item < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 3))
					0:       v = 8'h00;
					1:       v = 8'hFF;
					default: v = 8'($urandom);
				endcase
				set_version(v);
			end
			random_connection();
		end
	endtask

	task automatic test_steady_stream();
		wait_idle();
		tx_gaps_on = 1'b0;
		rx_gaps_on = 1'b0;
		send_open();
		send_data(version_reg);
		fill_body(int'(LEN_ACTION), FILL_RANDOM);
		send_frame(TYPE_ACTION, LEN_ACTION);
	endtask

	initial begin
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		in_data     <= '0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		reset_model();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_stray_bytes();
		test_handshake_reject();
		test_action_and_mouse();
		test_length_cases();
		test_scancode();
		test_version_register();
		test_backpressure();
		test_random_traffic();
		test_steady_stream();

		wait_idle();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0) begin
			$display("PASS tlv_input_message_deframer_top");
		end else begin
			$display("FAIL tlv_input_message_deframer_top");
		end
		$finish;
	end

endmodule
